>>> hdl/stbs_pkg.sv
package stbs_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W       = 8;
  localparam int VALUE_W     = 32;

  // Item commands.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic [POS_W-1:0]          entry_position;
    logic signed [VALUE_W-1:0] item_value;
  } item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_position;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept_write;
    logic start_search;
    logic probe;
    logic compare;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic window_empty;
    logic key_match;
  } dp_status_t;

endpackage

>>> hdl/stbs_ram.sv
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/stbs_ctrl.sv
module stbs_ctrl
  import stbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       item_cmd,
  output logic       item_stall,
  output logic       result_valid,
  input  logic       result_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_PROBE   = 4'b0010,
    S_COMPARE = 4'b0100,
    S_FINISH  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_full;
  logic   out_full_next;

  assign item_stall   = (state != S_IDLE);
  assign result_valid = out_full;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (item_cmd == CMD_SEARCH) begin
            cmd.start_search = 1'b1;
            state_next       = S_PROBE;
          end else begin
            cmd.accept_write = 1'b1;
          end
        end
      end
      S_PROBE: begin
        cmd.probe  = 1'b1;
        state_next = status.window_empty ? S_FINISH : S_COMPARE;
      end
      S_COMPARE: begin
        cmd.compare = 1'b1;
        state_next  = status.key_match ? S_FINISH : S_PROBE;
      end
      S_FINISH: begin
        if (!out_full || !result_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_full_next = out_full;
    if (cmd.load_out) begin
      out_full_next = 1'b1;
    end else if (!result_stall) begin
      out_full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

endmodule

>>> hdl/stbs_dpath.sv
module stbs_dpath
  import stbs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           cmd,
  output dp_status_t          status,
  input  item_t               item,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_data,
  output result_t             result
);

  logic [COUNT_W-1:0]        entry_count;
  logic signed [VALUE_W-1:0] key;
  logic [COUNT_W-1:0]        low;
  logic [COUNT_W-1:0]        high_excl;
  logic [ADDR_W-1:0]         mid;
  logic [COUNT_W-1:0]        mid_calc;
  logic [COUNT_W-1:0]        span;
  logic [VALUE_W-1:0]        rdata;
  logic                      key_less;
  logic                      res_found;
  logic [POS_W-1:0]          res_pos;
  logic                      ram_we;

  // Window [low, high_excl); midpoint rounds down: low + (high_excl - low - 1) / 2.
  assign span     = high_excl - low - COUNT_W'(1);
  assign mid_calc = low + (span >> 1);

  assign status.window_empty = !(low < high_excl);
  assign status.key_match    = ($signed(rdata) == key);
  assign key_less            = ($signed(rdata) < key);

  assign ram_we = cmd.accept_write
                  && ({1'b0, item.entry_position} < (POS_W + 1)'(TABLE_DEPTH));

  stbs_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(item.entry_position[ADDR_W-1:0]),
    .wdata(item.item_value),
    .re   (cmd.probe),
    .raddr(mid_calc[ADDR_W-1:0]),
    .rdata(rdata)
  );

  // A count above the table depth is held at the depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= (cfg_data > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH) : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_search) begin
      key       <= item.item_value;
      low       <= '0;
      high_excl <= entry_count;
    end
    if (cmd.probe) begin
      mid <= mid_calc[ADDR_W-1:0];
      if (status.window_empty) begin
        res_found <= 1'b0;
        res_pos   <= '0;
      end
    end
    if (cmd.compare) begin
      if (status.key_match) begin
        res_found <= 1'b1;
        res_pos   <= POS_W'(mid);
      end else if (key_less) begin
        low <= COUNT_W'(mid) + COUNT_W'(1);
      end else begin
        high_excl <= COUNT_W'(mid);
      end
    end
    if (cmd.load_out) begin
      result.found          <= res_found;
      result.match_position <= res_pos;
    end
  end

endmodule

>>> hdl/sorted_table_binary_search_unit.sv
// Sorted-table binary search unit. The block holds a table of 256 signed 32-bit
// entries that software keeps sorted in ascending order. A write beat (cmd 0)
// stores item_value at entry_position and produces no result. A search beat
// (cmd 1) looks up item_value among the first entry_count entries with the
// classic binary search over the window [low, high) (midpoint low + (high - low
// - 1) / 2) and produces one result beat holding a found flag and the position
// of the first probe that matched, or zero when the key is not found. Each probe
// has a probe step for the registered table read and a compare step for the
// compare and window update. A search that misses ends with one more probe step
// that finds the window empty. A full 256-entry table needs at most nine probes.
// The block works on one item at a time and holds item_stall high while a search
// is in progress; a finished result waits in an output register, so the next
// item is accepted even while the result is stalled. entry_count is written
// through the cfg channel, which is always ready; values above 256 are treated
// as 256. The count should only be changed while the block is idle. Table
// entries hold no reset value, so every entry below entry_count must be written
// before a search.

module sorted_table_binary_search_unit
  import stbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Item channel.
  input  logic               item_valid,
  output logic               item_stall,
  input  item_t              item,
  // Result channel.
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result,
  // Configuration channel: entry_count.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Configuration writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  // The controller sequences probes; it sees only the command bit of an item.
  stbs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_cmd    (item.cmd),
    .item_stall  (item_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .status      (status),
    .cmd         (cmd)
  );

  // The datapath holds the table, the search window and the result register.
  stbs_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .item    (item),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .result  (result)
  );

endmodule
